[rtl/windowed_power_mean_db_meter_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the dB level meter
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_POWER_MEAN_DB_METER_TOP_MACROS_SVH
`define WINDOWED_POWER_MEAN_DB_METER_TOP_MACROS_SVH

// same-cycle implication
`define WPM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/wpm_pkg.sv]
// ----------------------------------------------------------------------------
// wpm_pkg
// Types, constants and small tables shared by the level meter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wpm_pkg;

    localparam int ADC_W  = 10;
    localparam int DB_W   = 16;
    localparam int BARS_W = 6;
    localparam int WIN_W  = 14;
    localparam int CNT_W  = 16;
    localparam int PWR_W  = 64;

    localparam int ADC_BITS_DEF      = 10;
    localparam int DB_FRAC_BITS_DEF  = 8;
    localparam int ACC_FRAC_BITS_DEF = 32;
    localparam int BAR_COUNT_DEF     = 47;

    localparam logic [WIN_W-1:0] WINDOW_MS_RST  = '0;
    localparam logic [ADC_W-1:0] ADC_OFFSET_RST = 10'd744;

    // register indexes
    localparam logic CFG_WINDOW_MS  = 1'b0;
    localparam logic CFG_ADC_OFFSET = 1'b1;

    localparam int DB_SCALE_NUM   = 2000;
    localparam int DB_SCALE_DEN   = 18569;
    localparam int BAR_ZERO_INDEX = 33;

    localparam logic [31:0] LOG2_10_DIV10_Q32 = 32'd1426757253;
    localparam logic [31:0] LN2_Q32           = 32'd2977044472;
    localparam logic [31:0] TEN_LOG10_2_Q28   = 32'd808071242;

    typedef struct packed {
        logic [WIN_W-1:0] window_ms;
        logic [ADC_W-1:0] adc_offset;
    } cfg_regs_t;

    typedef struct packed {
        logic                   valid;
        logic signed [DB_W-1:0] db;
    } db_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // mask for the used converter bits
    function automatic logic [ADC_W-1:0] adc_mask(input int bits);
        logic [ADC_W:0] one_hot;
        one_hot = (ADC_W+1)'(1) << ((bits < ADC_W) ? bits : ADC_W);
        return ADC_W'(one_hot - (ADC_W+1)'(1));
    endfunction

    // ceil(2^36 / k): exact floor division by k for 32-bit dividends
    function automatic logic [36:0] recip(input logic [3:0] k);
        logic [36:0] r;
        case (k)
            4'd1:    r = 37'd68719476736;
            4'd2:    r = 37'd34359738368;
            4'd3:    r = 37'd22906492246;
            4'd4:    r = 37'd17179869184;
            4'd5:    r = 37'd13743895348;
            4'd6:    r = 37'd11453246123;
            4'd7:    r = 37'd9817068106;
            4'd8:    r = 37'd8589934592;
            4'd9:    r = 37'd7635497416;
            4'd10:   r = 37'd6871947674;
            4'd11:   r = 37'd6247225158;
            4'd12:   r = 37'd5726623062;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/wpm_front.sv]
// ----------------------------------------------------------------------------
// wpm_front
// Takes a sample, scales it to a Q dB level by reciprocal multiply, queues it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpm_front #(
    parameter int ADC_BITS     = wpm_pkg::ADC_BITS_DEF,
    parameter int DB_FRAC_BITS = wpm_pkg::DB_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [wpm_pkg::ADC_W-1:0]    adc_sample,
    input  logic [wpm_pkg::ADC_W-1:0]    adc_offset,
    input  wpm_pkg::q_stat_t             q_stat,
    output wpm_pkg::db_push_t            q_push
);
    import wpm_pkg::*;

    localparam int MAG_W  = ADC_W + 12 + DB_FRAC_BITS;
    localparam int SW     = MAG_W + 1;
    localparam int DB_OFS = (221 * (1 << DB_FRAC_BITS) + 50) / 100;
    // quotient width: the divisor is above 2^14
    localparam int QW     = MAG_W - 14;
    // ceil(2^RS / den) gives exact floor division for MAG_W-bit dividends
    localparam int RS     = MAG_W + 15;
    localparam int RC_W   = RS - 14;
    localparam int PW     = MAG_W + RC_W;
    localparam logic [63:0] RECIP_C =
        ((64'd1 << RS) + 64'(DB_SCALE_DEN) - 64'd1) / 64'(DB_SCALE_DEN);
    localparam logic [ADC_W-1:0] SMP_MASK = adc_mask(ADC_BITS);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

    fstate_t              state_reg;
    logic [MAG_W-1:0]     dvd_reg;
    logic [QW-1:0]        quo_reg;
    logic                 neg_reg;

    logic [ADC_W-1:0]        smp;
    logic signed [ADC_W:0]   diff;
    logic [ADC_W-1:0]        absd;
    logic [ADC_W+10:0]       scaled;
    logic [MAG_W-1:0]        mag;
    logic [PW-1:0]           prod;
    logic [SW-1:0]           qmag;
    logic signed [SW-1:0]    qs;
    logic signed [SW-1:0]    qsum;
    logic signed [DB_W-1:0]  db_sat;

    assign smp    = adc_sample & SMP_MASK;
    assign diff   = $signed({1'b0, smp}) - $signed({1'b0, adc_offset});
    assign absd   = diff[ADC_W] ? ADC_W'(-diff) : diff[ADC_W-1:0];
    assign scaled = (ADC_W+11)'(absd) * (ADC_W+11)'(DB_SCALE_NUM);
    assign mag    = (MAG_W'(scaled) << DB_FRAC_BITS) + MAG_W'(DB_SCALE_DEN / 2);

    assign prod = PW'(dvd_reg) * PW'(RECIP_C[RC_W-1:0]);

    assign qmag = SW'(quo_reg);
    assign qs   = neg_reg ? -$signed(qmag) : $signed(qmag);
    assign qsum = qs + SW'(DB_OFS);

    always_comb
    begin
        if (qsum > SW'(32767))
            db_sat = 16'sh7FFF;
        else if (qsum < -SW'(32768))
            db_sat = 16'sh8000;
        else
            db_sat = qsum[DB_W-1:0];
    end

    assign in_stall     = (state_reg != F_IDLE);
    assign q_push.valid = (state_reg == F_PUSH) && !q_stat.full;
    assign q_push.db    = db_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        dvd_reg   <= mag;
                        neg_reg   <= diff[ADC_W];
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    quo_reg   <= prod[PW-1:RS];
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_stat.full)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/wpm_queue.sv]
// ----------------------------------------------------------------------------
// wpm_queue
// Two-entry queue of sample levels between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpm_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wpm_pkg::db_push_t               q_push,
    input  logic                            q_pop,
    output logic signed [wpm_pkg::DB_W-1:0] q_data,
    output wpm_pkg::q_stat_t                q_stat
);
    import wpm_pkg::*;

    logic signed [DB_W-1:0] mem [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             fill_reg;

    assign q_stat.full  = (fill_reg == 2'd2);
    assign q_stat.empty = (fill_reg == 2'd0);
    assign q_data       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (q_push.valid)
            mem[wr_ptr_reg] <= q_push.db;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            if (q_push.valid)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({q_push.valid, q_pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

[rtl/wpm_back.sv]
// ----------------------------------------------------------------------------
// wpm_back
// Power by exp series, saturating accumulation, and on window close the
// mean level by serial divide, normalize and log2 squaring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wpm_back #(
    parameter int DB_FRAC_BITS  = wpm_pkg::DB_FRAC_BITS_DEF,
    parameter int ACC_FRAC_BITS = wpm_pkg::ACC_FRAC_BITS_DEF,
    parameter int BAR_COUNT     = wpm_pkg::BAR_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [wpm_pkg::WIN_W-1:0]         window_ms,
    input  wpm_pkg::q_stat_t                  q_stat,
    input  logic signed [wpm_pkg::DB_W-1:0]   q_data,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [wpm_pkg::DB_W-1:0]   mean_level_db,
    output logic [wpm_pkg::BARS_W-1:0]        lit_bars,
    output logic signed [wpm_pkg::DB_W-1:0]   sample_level_db
);
    import wpm_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE, B_EXP, B_LN, B_TMUL, B_TDIV, B_SHIFT, B_ACC,
        B_DIV, B_NORM, B_SQ, B_LMUL, B_MEAN, B_OUT
    } bstate_t;

    bstate_t                state_reg;
    logic signed [DB_W-1:0] q_reg;
    logic [31:0]            r_reg;
    logic signed [15:0]     s_reg;
    logic [31:0]            z_reg;
    logic [32:0]            t_reg;
    logic [34:0]            m_reg;
    logic [31:0]            x_reg;
    logic [3:0]             k_reg;
    logic [PWR_W-1:0]       p_reg;
    logic [PWR_W-1:0]       sum_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [PWR_W-1:0]       dvd_reg;
    logic [CNT_W-1:0]       dsr_reg;
    logic [CNT_W-1:0]       rem_reg;
    logic [5:0]             dcnt_reg;
    logic [5:0]             b_reg;
    logic [31:0]            y_reg;
    logic [23:0]            frac_reg;
    logic [4:0]             i_reg;
    logic signed [63:0]     lprod_reg;
    logic                   zero_reg;
    logic signed [DB_W-1:0] mean_reg;
    logic                   out_valid_reg;
    logic signed [DB_W-1:0] mean_out_reg;
    logic [BARS_W-1:0]      bars_out_reg;
    logic signed [DB_W-1:0] smp_out_reg;

    logic signed [47:0]  e_w;
    logic signed [47:0]  n_w;
    logic signed [15:0]  s_w;
    logic [63:0]         zprod;
    logic [64:0]         tprod;
    logic [68:0]         dprod;
    logic [32:0]         t_new;
    logic [15:0]         neg_s;
    logic [PWR_W-1:0]    pw;
    logic [PWR_W:0]      sum_wide;
    logic [PWR_W-1:0]    sum_next;
    logic [CNT_W-1:0]    cnt_next;
    logic                close_w;
    logic [CNT_W:0]      dtrial;
    logic                dge;
    logic [63:0]         sq;
    logic signed [7:0]   bma;
    logic signed [32:0]  l_w;
    logic signed [63:0]  mv;
    logic signed [63:0]  msh;
    logic signed [DB_W-1:0] mean_sat;
    logic signed [16:0]  bi;
    logic signed [16:0]  bc;
    logic [BARS_W-1:0]   bars_w;
    logic                load_out;

    // power of the popped level
    assign e_w   = q_reg * $signed({16'd0, LOG2_10_DIV10_Q32});
    assign n_w   = e_w >>> (DB_FRAC_BITS + 32);
    assign s_w   = $signed(16'(n_w)) + $signed(16'(ACC_FRAC_BITS - 32));
    assign zprod = 64'(r_reg) * 64'(LN2_Q32);
    assign tprod = 65'(t_reg) * 65'(z_reg);
    assign dprod = 69'(x_reg) * 69'(recip(k_reg));
    assign t_new = dprod[68:36];
    assign neg_s = 16'(-s_reg);

    always_comb
    begin
        if (s_reg > 16'sd30)
            pw = '1;
        else if (!s_reg[15])
            pw = PWR_W'(m_reg) << s_reg[4:0];
        else if (neg_s >= 16'd64)
            pw = '0;
        else
            pw = PWR_W'(m_reg) >> neg_s[5:0];
    end

    // accumulate and window test
    assign sum_wide = {1'b0, sum_reg} + {1'b0, p_reg};
    assign sum_next = sum_wide[PWR_W] ? '1 : sum_wide[PWR_W-1:0];
    assign cnt_next = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
    assign close_w  = (25'(cnt_next) * 25'd200) > (25'(window_ms) * 25'd441);

    // restoring divide, one quotient bit per cycle
    assign dtrial = {rem_reg, dvd_reg[PWR_W-1]};
    assign dge    = dtrial >= {1'b0, dsr_reg};

    // log2 fraction by squaring
    assign sq  = 64'(y_reg) * 64'(y_reg);
    assign bma = $signed({2'b00, b_reg}) - $signed(8'(ACC_FRAC_BITS));
    assign l_w = $signed({bma[7], bma, frac_reg});

    assign mv  = lprod_reg + (64'sd1 <<< (51 - DB_FRAC_BITS));
    assign msh = mv >>> (52 - DB_FRAC_BITS);

    always_comb
    begin
        if (zero_reg)
            mean_sat = 16'sh8000;
        else if (msh > 64'sd32767)
            mean_sat = 16'sh7FFF;
        else if (msh < -64'sd32768)
            mean_sat = 16'sh8000;
        else
            mean_sat = msh[DB_W-1:0];
    end

    // bar count from the emitted mean
    assign bi = 17'(mean_reg >>> DB_FRAC_BITS) + 17'sd33;

    always_comb
    begin
        if (bi < 17'sd0)
            bc = 17'sd0;
        else if (bi > 17'(BAR_COUNT - 1))
            bc = 17'(BAR_COUNT - 1);
        else
            bc = bi;
        bc = bc + 17'sd1;
        if (bc > 17'sd63)
            bc = 17'sd63;
        bars_w = bc[BARS_W-1:0];
    end

    assign q_pop     = (state_reg == B_IDLE) && !q_stat.empty;
    assign load_out  = (state_reg == B_OUT) && (!out_valid_reg || !out_stall);

    assign out_valid       = out_valid_reg;
    assign mean_level_db   = mean_out_reg;
    assign lit_bars        = bars_out_reg;
    assign sample_level_db = smp_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                mean_out_reg  <= mean_reg;
                bars_out_reg  <= bars_w;
                smp_out_reg   <= q_reg;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                B_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        q_reg     <= q_data;
                        state_reg <= B_EXP;
                    end
                end
                B_EXP:
                begin
                    r_reg     <= e_w[DB_FRAC_BITS+31:DB_FRAC_BITS];
                    s_reg     <= s_w;
                    state_reg <= B_LN;
                end
                B_LN:
                begin
                    z_reg     <= zprod[63:32];
                    t_reg     <= 33'h1_0000_0000;
                    m_reg     <= 35'h1_0000_0000;
                    k_reg     <= 4'd1;
                    state_reg <= B_TMUL;
                end
                B_TMUL:
                begin
                    x_reg     <= tprod[63:32];
                    state_reg <= B_TDIV;
                end
                B_TDIV:
                begin
                    t_reg <= t_new;
                    m_reg <= m_reg + 35'(t_new);
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 4'd12)
                        state_reg <= B_SHIFT;
                    else
                        state_reg <= B_TMUL;
                end
                B_SHIFT:
                begin
                    p_reg     <= pw;
                    state_reg <= B_ACC;
                end
                B_ACC:
                begin
                    if (close_w)
                    begin
                        dvd_reg   <= sum_next;
                        dsr_reg   <= cnt_next;
                        rem_reg   <= '0;
                        dcnt_reg  <= '0;
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= B_DIV;
                    end
                    else
                    begin
                        sum_reg   <= sum_next;
                        cnt_reg   <= cnt_next;
                        state_reg <= B_IDLE;
                    end
                end
                B_DIV:
                begin
                    rem_reg  <= dge ? CNT_W'(dtrial - {1'b0, dsr_reg}) : dtrial[CNT_W-1:0];
                    dvd_reg  <= {dvd_reg[PWR_W-2:0], dge};
                    dcnt_reg <= dcnt_reg + 1'b1;
                    b_reg    <= 6'd63;
                    if (dcnt_reg == 6'd63)
                        state_reg <= B_NORM;
                end
                B_NORM:
                begin
                    if (dvd_reg == '0)
                    begin
                        zero_reg  <= 1'b1;
                        state_reg <= B_MEAN;
                    end
                    else if (!dvd_reg[PWR_W-1])
                    begin
                        dvd_reg <= dvd_reg << 1;
                        b_reg   <= b_reg - 1'b1;
                    end
                    else
                    begin
                        zero_reg  <= 1'b0;
                        y_reg     <= dvd_reg[PWR_W-1:PWR_W-32];
                        frac_reg  <= '0;
                        i_reg     <= '0;
                        state_reg <= B_SQ;
                    end
                end
                B_SQ:
                begin
                    y_reg    <= sq[63] ? sq[63:32] : sq[62:31];
                    frac_reg <= {frac_reg[22:0], sq[63]};
                    i_reg    <= i_reg + 1'b1;
                    if (i_reg == 5'd23)
                        state_reg <= B_LMUL;
                end
                B_LMUL:
                begin
                    lprod_reg <= l_w * $signed({32'd0, TEN_LOG10_2_Q28});
                    state_reg <= B_MEAN;
                end
                B_MEAN:
                begin
                    mean_reg  <= mean_sat;
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (load_out)
                        state_reg <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/windowed_power_mean_db_meter_top.sv]
// ----------------------------------------------------------------------------
// windowed_power_mean_db_meter_top
// Windowed power-mean dB level meter for a log-amplifier converter stream.
//
// Input channel (in_valid / in_stall / adc_sample): one request per sample.
// The front end scales the sample to a Q dB level by a reciprocal multiply
// (accept, multiply, push). Levels wait in a two-entry queue for the back
// end, which runs the exp series (12 terms, two steps each) and the
// saturating accumulate on each sample before it pops the next one, and
// which thereby sets the sustained rate at which samples are taken.
// When count*200 > window_ms*441 a result request leaves on the output
// channel: the mean level, the lit bar count and the closing sample's level.
// A closing window adds a serial divide of the 64-bit sum by the count, a
// normalize loop, 24 log squaring steps, the log multiply and the mean saturation.
// Output stall holds the result register; the back end waits on it, then
// the queue fills and in_stall rises. Config (cfg_valid/cfg_ready) is always
// ready. Reset clears the count, the accumulator and both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "windowed_power_mean_db_meter_top_macros.svh"

module windowed_power_mean_db_meter_top #(
    parameter int ADC_BITS      = wpm_pkg::ADC_BITS_DEF,
    parameter int DB_FRAC_BITS  = wpm_pkg::DB_FRAC_BITS_DEF,
    parameter int ACC_FRAC_BITS = wpm_pkg::ACC_FRAC_BITS_DEF,
    parameter int BAR_COUNT     = wpm_pkg::BAR_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [wpm_pkg::ADC_W-1:0]         adc_sample,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [wpm_pkg::DB_W-1:0]   mean_level_db,
    output logic [wpm_pkg::BARS_W-1:0]        lit_bars,
    output logic signed [wpm_pkg::DB_W-1:0]   sample_level_db,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [wpm_pkg::WIN_W-1:0]         cfg_data
);
    import wpm_pkg::*;

    localparam logic [ADC_W-1:0] OFS_MASK = adc_mask(ADC_BITS);

    cfg_regs_t              cfg_reg;
    db_push_t               q_push;
    q_stat_t                q_stat;
    logic                   q_pop;
    logic signed [DB_W-1:0] q_data;

    // The user must write config only while idle; the block does not enforce it, so no hazard handling here.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_ms  <= WINDOW_MS_RST;
            cfg_reg.adc_offset <= ADC_OFFSET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WINDOW_MS:  cfg_reg.window_ms  <= cfg_data;
                CFG_ADC_OFFSET: cfg_reg.adc_offset <= cfg_data[ADC_W-1:0] & OFS_MASK;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // front: sample -> dB level
    wpm_front #(
        .ADC_BITS     (ADC_BITS),
        .DB_FRAC_BITS (DB_FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .adc_sample (adc_sample),
        .adc_offset (cfg_reg.adc_offset),
        .q_stat     (q_stat),
        .q_push     (q_push)
    );

    // decoupling queue
    wpm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_pop  (q_pop),
        .q_data (q_data),
        .q_stat (q_stat)
    );

    // back: power, accumulate, mean and bars
    wpm_back #(
        .DB_FRAC_BITS  (DB_FRAC_BITS),
        .ACC_FRAC_BITS (ACC_FRAC_BITS),
        .BAR_COUNT     (BAR_COUNT)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .window_ms       (cfg_reg.window_ms),
        .q_stat          (q_stat),
        .q_data          (q_data),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .mean_level_db   (mean_level_db),
        .lit_bars        (lit_bars),
        .sample_level_db (sample_level_db)
    );

    // an accepted sample keeps the front busy for the multiply
    `WPM_ASSERT_NEXT(a_front_busy, in_valid && !in_stall, in_stall, "front took a second sample")
    // the queue is never written when full
    `WPM_ASSERT_IMPLY(a_q_no_ovf, q_push.valid, !q_stat.full, "level queue overflow")
    // the back end never pops an empty queue
    `WPM_ASSERT_IMPLY(a_q_no_unf, q_pop, !q_stat.empty, "level queue underflow")
    // bar count stays within the meter
    `WPM_ASSERT_IMPLY(a_bars_rng, out_valid,
        lit_bars != '0 && {1'b0, lit_bars} <= 7'(BAR_COUNT), "lit_bars out of range")

endmodule
